[design/hrwl_pkg.sv]
package hrwl_pkg;

    localparam int HASH_W   = 64;
    localparam int BYTE_W   = 8;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 11;
    localparam int BUCKET_W = 10;
    localparam int SHIFT    = 5;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam logic [CFG_W-1:0]  NUM_LOCKS_RESET = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNLOCK = 2'd2;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_BUSY     = 2'd1,
        ST_NOT_HELD = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_HASH,
        S_DIV,
        S_READ,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic clear;
        logic read;
        logic write;
    } t_tbl_cmd;

endpackage

[design/hrwl_hash.sv]
module hrwl_hash (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic signed [hrwl_pkg::BYTE_W-1:0] i_key_byte,
    input  logic                             i_byte_valid,
    input  logic                             i_last_byte,
    output logic [hrwl_pkg::HASH_W-1:0]      o_fold
);

    logic [hrwl_pkg::HASH_W-1:0] r_hash;
    logic [hrwl_pkg::HASH_W-1:0] n_hash;
    logic [hrwl_pkg::HASH_W-1:0] byte_ext;

    // hash * 33 + sign-extended byte, wrapping
    always_comb begin
        byte_ext = {{(hrwl_pkg::HASH_W-hrwl_pkg::BYTE_W){i_key_byte[hrwl_pkg::BYTE_W-1]}},
                    i_key_byte};
        if (i_byte_valid) begin
            o_fold = (r_hash << hrwl_pkg::SHIFT) + r_hash + byte_ext;
        end else begin
            o_fold = r_hash;
        end
        n_hash = i_last_byte ? hrwl_pkg::HASH_SEED : o_fold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= hrwl_pkg::HASH_SEED;
        end else if (i_accept) begin
            r_hash <= n_hash;
        end
    end

endmodule

[design/hrwl_div.sv]
module hrwl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hrwl_pkg::HASH_W-1:0] i_dividend,
    input  logic [hrwl_pkg::CFG_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [hrwl_pkg::CFG_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(hrwl_pkg::HASH_W);

    logic [hrwl_pkg::HASH_W-1:0] r_dvd;
    logic [hrwl_pkg::CFG_W-1:0]  r_div;
    logic [hrwl_pkg::CFG_W-1:0]  r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [hrwl_pkg::CFG_W:0]    trial;
    logic [hrwl_pkg::CFG_W:0]    n_part;

    // one quotient bit a cycle: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[hrwl_pkg::HASH_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_part = trial - {1'b0, r_div};
        end else begin
            n_part = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(hrwl_pkg::HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_part[hrwl_pkg::CFG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[design/hrwl_table.sv]
module hrwl_table #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_READERS = 255,
    parameter int IW          = 10,
    parameter int CW          = 8
) (
    input  logic                       i_clk,
    input  hrwl_pkg::t_tbl_cmd         i_cmd,
    input  logic [IW-1:0]              i_addr,
    input  logic [hrwl_pkg::REQ_W-1:0] i_req,
    output hrwl_pkg::t_status          o_status
);

    localparam int EW = CW + 1;

    logic [EW-1:0] mem [MAX_BUCKETS];
    logic [EW-1:0] r_rd_data;
    logic [EW-1:0] n_entry;
    logic [EW-1:0] wr_data;
    logic          writer;
    logic [CW-1:0] count;

    assign writer = r_rd_data[CW];
    assign count  = r_rd_data[CW-1:0];

    always_comb begin
        n_entry  = r_rd_data;
        o_status = hrwl_pkg::ST_BUSY;
        unique case (i_req)
            hrwl_pkg::REQ_READ: begin
                if (writer) begin
                    o_status = hrwl_pkg::ST_BUSY;
                end else if (count >= CW'(MAX_READERS)) begin
                    o_status = hrwl_pkg::ST_OVERFLOW;
                end else begin
                    n_entry  = {1'b0, count + 1'b1};
                    o_status = hrwl_pkg::ST_GRANTED;
                end
            end
            hrwl_pkg::REQ_WRITE: begin
                if (writer || count != '0) begin
                    o_status = hrwl_pkg::ST_BUSY;
                end else begin
                    n_entry  = {1'b1, count};
                    o_status = hrwl_pkg::ST_GRANTED;
                end
            end
            hrwl_pkg::REQ_UNLOCK: begin
                if (writer) begin
                    n_entry  = {1'b0, count};
                    o_status = hrwl_pkg::ST_GRANTED;
                end else if (count != '0) begin
                    n_entry  = {1'b0, count - 1'b1};
                    o_status = hrwl_pkg::ST_GRANTED;
                end else begin
                    o_status = hrwl_pkg::ST_NOT_HELD;
                end
            end
            default: begin
                // undefined request: leave the entry alone
                o_status = hrwl_pkg::ST_BUSY;
            end
        endcase
        wr_data = i_cmd.clear ? '0 : n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write || i_cmd.clear) begin
            mem[i_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_rd_data <= mem[i_addr];
        end
    end

endmodule

[design/hashed_reader_writer_lock_table_core.sv]
// Hashed reader/writer lock table.
//
// Input channel (i_in_valid / o_in_stall): one key byte per word, with a
// byte-valid flag and a last-byte mark; the request code is taken from the
// word that carries the last-byte mark. Bytes fold into a 64-bit hash at one
// word per unstalled cycle. Output channel (o_out_valid / i_out_stall): one
// word per finished key with the bucket, the status code and a granted flag.
// Sequence after the last byte is taken: a bit-serial remainder in hrwl_div,
// its done flag, one table read, then one read-modify-write. The input
// stalls from the last byte until the table write-back.
// Reset: the hash reloads its seed and a clearing pass zeroes the table,
// one bucket a cycle, with the input stalled; the num_locks register may be
// written during the pass.
// Output stall: a finished result waits in the output register; bytes of
// the next key are still taken and its remainder still runs, and only its
// table write-back holds until the output register frees up.
module hashed_reader_writer_lock_table_core #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_READERS = 255
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [hrwl_pkg::CFG_W-1:0]         i_cfg_wr_data,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [hrwl_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [hrwl_pkg::BYTE_W-1:0] i_key_byte,
    input  logic                               i_byte_valid,
    input  logic                               i_last_byte,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [hrwl_pkg::BUCKET_W-1:0]      o_bucket,
    output logic [1:0]                         o_status,
    output logic                               o_granted
);

    localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = (MAX_READERS > 1) ? $clog2(MAX_READERS + 1) : 1;
    // saturation value of the divisor, limited to what the register can hold
    localparam logic [hrwl_pkg::CFG_W-1:0] DIV_SAT =
        (MAX_BUCKETS > (2 ** hrwl_pkg::CFG_W) - 1) ? {hrwl_pkg::CFG_W{1'b1}}
                                                   : hrwl_pkg::CFG_W'(MAX_BUCKETS);

    hrwl_pkg::t_state r_state;
    hrwl_pkg::t_state n_state;

    logic [hrwl_pkg::CFG_W-1:0]  r_num_locks;
    logic [IW-1:0]               r_clr;
    logic [hrwl_pkg::REQ_W-1:0]  r_req;

    logic                        r_out_valid;
    logic [hrwl_pkg::BUCKET_W-1:0] r_bucket;
    hrwl_pkg::t_status           r_status;

    logic                        in_accept;
    logic                        key_done;
    logic                        out_free;
    logic [hrwl_pkg::HASH_W-1:0] fold;
    logic [hrwl_pkg::CFG_W-1:0]  divisor;
    logic                        div_done;
    logic [hrwl_pkg::CFG_W-1:0]  rem;
    logic [IW-1:0]               tbl_addr;
    hrwl_pkg::t_tbl_cmd          tbl_cmd;
    hrwl_pkg::t_status           tbl_status;

    assign in_accept = i_in_valid && !o_in_stall;
    assign key_done  = in_accept && i_last_byte;
    assign out_free  = !r_out_valid || !i_out_stall;

    // divisor in use: zero acts as one, large values saturate
    always_comb begin
        if (r_num_locks == '0) begin
            divisor = hrwl_pkg::CFG_W'(1);
        end else if (32'(r_num_locks) > MAX_BUCKETS) begin
            divisor = DIV_SAT;
        end else begin
            divisor = r_num_locks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_locks <= hrwl_pkg::NUM_LOCKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_num_locks <= i_cfg_wr_data;
        end
    end

    hrwl_hash u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_key_byte   (i_key_byte),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .o_fold       (fold)
    );

    hrwl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (key_done),
        .i_dividend (fold),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    hrwl_table #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_READERS (MAX_READERS),
        .IW          (IW),
        .CW          (CW)
    ) u_table (
        .i_clk    (i_clk),
        .i_cmd    (tbl_cmd),
        .i_addr   (tbl_addr),
        .i_req    (r_req),
        .o_status (tbl_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrwl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: clear sweep, take bytes, wait on the remainder, read, write back
    always_comb begin
        n_state       = r_state;
        tbl_cmd.clear = 1'b0;
        tbl_cmd.read  = 1'b0;
        tbl_cmd.write = 1'b0;
        o_in_stall    = 1'b1;
        tbl_addr      = IW'(rem);
        unique case (r_state)
            hrwl_pkg::S_CLEAR: begin
                tbl_cmd.clear = 1'b1;
                tbl_addr      = r_clr;
                if (r_clr == IW'(MAX_BUCKETS - 1)) begin
                    n_state = hrwl_pkg::S_HASH;
                end
            end
            hrwl_pkg::S_HASH: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_last_byte) begin
                    n_state = hrwl_pkg::S_DIV;
                end
            end
            hrwl_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = hrwl_pkg::S_READ;
                end
            end
            hrwl_pkg::S_READ: begin
                tbl_cmd.read = 1'b1;
                n_state      = hrwl_pkg::S_WRITE;
            end
            hrwl_pkg::S_WRITE: begin
                // hold the write-back until the previous result is taken
                if (out_free) begin
                    tbl_cmd.write = 1'b1;
                    n_state       = hrwl_pkg::S_HASH;
                end
            end
            default: begin
                n_state = hrwl_pkg::S_CLEAR;
            end
        endcase
    end

    // sweep address: advance through every bucket once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == hrwl_pkg::S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_done) begin
            r_req <= i_req_type;
        end
    end

    // output register: load on write-back, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tbl_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_cmd.write) begin
            r_bucket <= rem[hrwl_pkg::BUCKET_W-1:0];
            r_status <= tbl_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bucket    = r_bucket;
    assign o_status    = r_status;
    assign o_granted   = (r_status == hrwl_pkg::ST_GRANTED);

endmodule
